[sv/gbaf_pkg.sv]
// ----------------------------------------------------------------------------
// gbaf_pkg
// Shared types and constants of the guillotine best-area-fit packer.
// ----------------------------------------------------------------------------
package gbaf_pkg;

   localparam int MaxRects  = 64;
   localparam int CoordBits = 15;
   localparam int IdxBits   = $clog2(MaxRects);
   localparam int CntBits   = $clog2(MaxRects + 1);
   localparam int AreaBits  = 2 * CoordBits;
   localparam int RectBits  = 4 * CoordBits;

   localparam logic [CoordBits-1:0] AtlasReset = CoordBits'(2048);

   localparam logic CSR_ATLAS_WIDTH  = 1'b0;
   localparam logic CSR_ATLAS_HEIGHT = 1'b1;

   localparam logic ACT_INIT  = 1'b0;
   localparam logic ACT_PLACE = 1'b1;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOFIT  = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   typedef struct packed {
      logic [CoordBits-1:0] x;
      logic [CoordBits-1:0] y;
      logic [CoordBits-1:0] w;
      logic [CoordBits-1:0] h;
   } rect_type;

   typedef struct packed {
      logic                 action;
      logic [CoordBits-1:0] req_width;
      logic [CoordBits-1:0] req_height;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [CoordBits-1:0] place_x;
      logic [CoordBits-1:0] place_y;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_SREAD, S_SWAIT, S_SEVAL, S_PRODUCT, S_DECIDE,
      S_MREAD, S_MWAIT, S_MWRITE, S_APPEND, S_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;    // capture input item
      logic init_list;   // entry 0 = atlas, count = 1
      logic clr_scan;    // index to zero, clear found
      logic rd_idx;      // read memory at index
      logic eval;        // compare fit, start product
      logic acc;         // accumulate best
      logic inc_idx;     // advance index
      logic set_best;    // index = best
      logic rd_next;     // read index + 1
      logic shift_wr;    // write shifted entry at index
      logic append;      // write next remainder
      logic commit;      // update count
      logic [1:0] status;
      logic set_status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic action;
      logic scan_end;    // index reached count
      logic found;
      logic full;        // remainders do not fit
      logic shift_end;   // index + 1 reached count
      logic rem_left;    // remainder still to append
   } sts_type;

endpackage

[sv/guillotine_best_area_fit_packer.sv]
// ----------------------------------------------------------------------------
// guillotine_best_area_fit_packer
// Guillotine free-rectangle packer with best-area-fit slot choice.
// ----------------------------------------------------------------------------
// One item at a time. An init item passes through the init state after
// acceptance before its response is offered. A place item scans every stored
// free rectangle through the list memory (read, wait, compare and multiply,
// accumulate per entry), then shifts the later entries down and appends up
// to two remainders; a request that fits nowhere or would overflow the list
// goes straight to its response. After reset the list holds one rectangle
// covering the 2048 x 2048 default atlas; atlas writes take effect at the
// next init item.
// ----------------------------------------------------------------------------
module guillotine_best_area_fit_packer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  gbaf_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gbaf_pkg::rsp_type             rsp_data,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [gbaf_pkg::CoordBits-1:0] csr_data
);
   import gbaf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   gbaf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   gbaf_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );
endmodule

[sv/gbaf_ram.sv]
// ----------------------------------------------------------------------------
// gbaf_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module gbaf_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[sv/gbaf_ctrl.sv]
// ----------------------------------------------------------------------------
// gbaf_ctrl
// Sequencer for init, scan, shift-down and append phases.
// ----------------------------------------------------------------------------
module gbaf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  gbaf_pkg::sts_type sts,
   output gbaf_pkg::cmd_type cmd
);
   import gbaf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.clr_scan = 1'b1;
               state_in     = S_INIT;
            end
         end
         S_INIT: begin
            if (sts.action == ACT_INIT) begin
               cmd.init_list  = 1'b1;
               cmd.status     = ST_OK;
               cmd.set_status = 1'b1;
               state_in       = S_RESP;
            end else begin
               state_in = S_SREAD;
            end
         end
         S_SREAD: begin
            if (sts.scan_end) begin
               state_in = S_DECIDE;
            end else begin
               cmd.rd_idx = 1'b1;
               state_in   = S_SWAIT;
            end
         end
         S_SWAIT:   state_in = S_SEVAL;
         S_SEVAL: begin
            cmd.eval = 1'b1;
            state_in = S_PRODUCT;
         end
         S_PRODUCT: begin
            cmd.acc     = 1'b1;
            cmd.inc_idx = 1'b1;
            state_in    = S_SREAD;
         end
         S_DECIDE: begin
            if (!sts.found) begin
               cmd.status     = ST_NOFIT;
               cmd.set_status = 1'b1;
               state_in       = S_RESP;
            end else if (sts.full) begin
               cmd.status     = ST_FULL;
               cmd.set_status = 1'b1;
               state_in       = S_RESP;
            end else begin
               cmd.set_best   = 1'b1;
               cmd.status     = ST_OK;
               cmd.set_status = 1'b1;
               state_in       = S_MREAD;
            end
         end
         S_MREAD: begin
            if (sts.shift_end) begin
               state_in = S_APPEND;
            end else begin
               cmd.rd_next = 1'b1;
               state_in    = S_MWAIT;
            end
         end
         S_MWAIT: begin
            // hold the read on the next entry so its data survives into the write
            cmd.rd_next = 1'b1;
            state_in    = S_MWRITE;
         end
         S_MWRITE: begin
            cmd.shift_wr = 1'b1;
            cmd.inc_idx  = 1'b1;
            state_in     = S_MREAD;
         end
         S_APPEND: begin
            if (sts.rem_left) begin
               cmd.append = 1'b1;
            end else begin
               cmd.commit = 1'b1;
               state_in   = S_RESP;
            end
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

[sv/gbaf_dp.sv]
// ----------------------------------------------------------------------------
// gbaf_dp
// Free-list memory, scan comparator, area multiplier and remainder logic.
// ----------------------------------------------------------------------------
module gbaf_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [gbaf_pkg::CoordBits-1:0] csr_data,
   input  gbaf_pkg::req_type             req_data,
   input  gbaf_pkg::cmd_type             cmd,
   output gbaf_pkg::sts_type             sts,
   output gbaf_pkg::rsp_type             rsp_data
);
   import gbaf_pkg::*;

   logic [CoordBits-1:0] atlas_w_ff, atlas_h_ff;
   req_type              req_ff;
   logic [CntBits-1:0]   count_ff, count_in;
   logic [CntBits-1:0]   idx_ff;
   logic [IdxBits-1:0]   best_ff;
   logic                 found_ff, fit_ff;
   logic [AreaBits-1:0]  area_ff, best_area_ff;
   rect_type             slot_ff;
   rect_type             cand_ff;
   logic [1:0]           appended_ff;
   rsp_type              rsp_ff;
   logic                 reset_fill_ff;

   logic                 wr_en;
   logic [IdxBits-1:0]   wr_addr, rd_addr;
   rect_type             wr_data, rd_data;

   gbaf_ram #(.Width(RectBits), .Depth(MaxRects)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // remainders of the chosen slot
   logic [CoordBits-1:0] rw, rh;
   rect_type             rem_r, rem_d, rem_next;
   logic                 need_r, need_d;
   logic [1:0]           need;
   logic [CntBits:0]     new_count;
   logic [IdxBits-1:0]   best_src;
   rect_type             best_rect;

   assign rw = req_ff.req_width;
   assign rh = req_ff.req_height;

   // best slot captured during the scan
   assign best_rect = slot_ff;
   assign need_r = (best_rect.w != rw) && (best_rect.h != '0);
   assign need_d = (rw != '0) && (best_rect.h != rh);
   assign need   = {1'b0, need_r} + {1'b0, need_d};
   assign new_count = {1'b0, count_ff} - 1'b1 + (CntBits+1)'(need);

   assign rem_r = '{x: best_rect.x + rw, y: best_rect.y, w: best_rect.w - rw, h: best_rect.h};
   assign rem_d = '{x: best_rect.x, y: best_rect.y + rh, w: rw, h: best_rect.h - rh};
   assign rem_next = (appended_ff == 2'd0 && need_r) ? rem_r : rem_d;
   assign best_src = best_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[IdxBits-1:0];
      wr_data = rd_data;
      rd_addr = idx_ff[IdxBits-1:0];
      if (cmd.init_list || reset_fill_ff) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = '{x: '0, y: '0, w: atlas_w_ff, h: atlas_h_ff};
      end else if (cmd.shift_wr) begin
         wr_en = 1'b1;
      end else if (cmd.append) begin
         wr_en   = 1'b1;
         wr_data = rem_next;
      end
      if (cmd.rd_next) begin
         rd_addr = IdxBits'(idx_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         atlas_w_ff <= AtlasReset;
         atlas_h_ff <= AtlasReset;
      end else if (csr_write) begin
         if (csr_index == CSR_ATLAS_WIDTH) begin
            atlas_w_ff <= csr_data;
         end else begin
            atlas_h_ff <= csr_data;
         end
      end
   end

   // reset list: count 1, and entry 0 written with the atlas in the first
   // cycle after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= CntBits'(1);
         reset_fill_ff <= 1'b1;
      end else begin
         reset_fill_ff <= 1'b0;
         count_ff      <= count_in;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.init_list) begin
         count_in = CntBits'(1);
      end else if (cmd.commit) begin
         count_in = new_count[CntBits-1:0];
      end
   end

   logic [AreaBits-1:0] prod;
   assign prod = AreaBits'(rd_data.w) * AreaBits'(rd_data.h);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.clr_scan) begin
         idx_ff      <= '0;
         found_ff    <= 1'b0;
         appended_ff <= '0;
      end
      if (cmd.eval) begin
         fit_ff  <= (rd_data.w >= rw) && (rd_data.h >= rh);
         area_ff <= prod;
      end
      if (cmd.acc && fit_ff && (!found_ff || area_ff <= best_area_ff)) begin
         found_ff     <= 1'b1;
         best_area_ff <= area_ff;
         best_ff      <= idx_ff[IdxBits-1:0];
      end
      if (cmd.inc_idx) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.set_best) begin
         idx_ff <= CntBits'(best_src);
      end
      if (cmd.append) begin
         idx_ff      <= idx_ff + 1'b1;
         appended_ff <= appended_ff + 1'b1;
      end
      if (cmd.set_status) begin
         rsp_ff.status  <= cmd.status;
         rsp_ff.place_x <= (cmd.status == ST_OK && req_ff.action == ACT_PLACE) ?
                           best_rect.x : '0;
         rsp_ff.place_y <= (cmd.status == ST_OK && req_ff.action == ACT_PLACE) ?
                           best_rect.y : '0;
      end
   end

   // capture the best slot's rectangle alongside its area
   always_ff @(posedge clock) begin
      if (cmd.acc && fit_ff && (!found_ff || area_ff <= best_area_ff)) begin
         slot_ff <= cand_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         cand_ff <= rd_data;
      end
   end

   assign sts.action    = req_ff.action;
   assign sts.scan_end  = (idx_ff >= count_ff);
   assign sts.found     = found_ff;
   assign sts.full      = new_count > (CntBits+1)'(MaxRects);
   assign sts.shift_end = (CntBits'(idx_ff + 1'b1) >= count_ff);
   assign sts.rem_left  = (appended_ff < need);
   assign rsp_data      = rsp_ff;
endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the guillotine best-area-fit packer: a free-list
// model predicts each response, random valid/stall idling on both channels.
// ----------------------------------------------------------------------------
import gbaf_pkg::*;

class packer_scoreboard;
   rect_type            free_list[MaxRects] =
      '{0: '{x: '0, y: '0, w: AtlasReset, h: AtlasReset}, default: '0};
   int unsigned         free_cnt = 1;
   logic [CoordBits-1:0] atlas_w = AtlasReset;
   logic [CoordBits-1:0] atlas_h = AtlasReset;
   rsp_type             pending[$];
   int unsigned         errors;

   function void set_reg(logic idx, logic [CoordBits-1:0] val);
      if (idx == CSR_ATLAS_WIDTH) atlas_w = val;
      else atlas_h = val;
   endfunction

   // predict the response of one accepted item and update the free list
   function void note_item(req_type r);
      rsp_type     rsp;
      rect_type    slot;
      rect_type    rem[2];
      int unsigned need;
      int          best;
      logic [63:0] waste, best_waste;
      rsp = '0;
      if (r.action == ACT_INIT) begin
         foreach (free_list[i]) free_list[i] = '0;
         free_list[0].w = atlas_w;
         free_list[0].h = atlas_h;
         free_cnt = 1;
         rsp.status = ST_OK;
         pending.push_back(rsp);
         return;
      end
      best = -1;
      best_waste = '0;
      for (int i = 0; i < free_cnt; i++) begin
         if (free_list[i].w >= r.req_width && free_list[i].h >= r.req_height) begin
            waste = 64'(free_list[i].w) * 64'(free_list[i].h)
                  - 64'(r.req_width) * 64'(r.req_height);
            // later entries win ties
            if (best < 0 || waste <= best_waste) begin
               best = i;
               best_waste = waste;
            end
         end
      end
      if (best < 0) begin
         rsp.status = ST_NOFIT;
         pending.push_back(rsp);
         return;
      end
      slot = free_list[best];
      need = 0;
      if (slot.w != r.req_width && slot.h != 0) begin
         rem[need] = '{x: slot.x + r.req_width, y: slot.y,
                       w: slot.w - r.req_width, h: slot.h};
         need++;
      end
      if (r.req_width != 0 && slot.h != r.req_height) begin
         rem[need] = '{x: slot.x, y: slot.y + r.req_height,
                       w: r.req_width, h: slot.h - r.req_height};
         need++;
      end
      if (free_cnt - 1 + need > MaxRects) begin
         rsp.status = ST_FULL;
         pending.push_back(rsp);
         return;
      end
      for (int i = best; i + 1 < free_cnt; i++) free_list[i] = free_list[i+1];
      free_cnt--;
      free_list[free_cnt] = '0;
      for (int i = 0; i < need; i++) begin
         free_list[free_cnt] = rem[i];
         free_cnt++;
      end
      rsp.status  = ST_OK;
      rsp.place_x = slot.x;
      rsp.place_y = slot.y;
      pending.push_back(rsp);
   endfunction

   function void check(rsp_type got);
      rsp_type exp_rsp;
      if (pending.size() == 0) begin
         $error("unexpected response %p", got);
         errors++;
         return;
      end
      exp_rsp = pending.pop_front();
      if (got.status !== exp_rsp.status) begin
         $error("status: expected %0d, got %0d", exp_rsp.status, got.status);
         errors++;
      end
      if (got.place_x !== exp_rsp.place_x) begin
         $error("place_x: expected %0d, got %0d", exp_rsp.place_x, got.place_x);
         errors++;
      end
      if (got.place_y !== exp_rsp.place_y) begin
         $error("place_y: expected %0d, got %0d", exp_rsp.place_y, got.place_y);
         errors++;
      end
   endfunction
endclass

module tb;
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write = 1'b0;
   logic                 csr_index = CSR_ATLAS_WIDTH;
   logic [CoordBits-1:0] csr_data = '0;

   packer_scoreboard placements = new();
   int unsigned      send_idle_pct = 31;
   int unsigned      recv_idle_pct = 64;

   guillotine_best_area_fit_packer i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_write, .csr_index, .csr_data
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // receiver: check every accepted response, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) placements.check(rsp_data);
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // hold the item until the block takes it, then maybe idle
   task automatic send_item(logic act, logic [CoordBits-1:0] w, logic [CoordBits-1:0] h);
      req_type r;
      r = '{action: act, req_width: w, req_height: h};
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      placements.note_item(r);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // one write, then a pause with the strobe low so back-to-back writes never collide
   task automatic write_reg(logic idx, logic [CoordBits-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      placements.set_reg(idx, val);
      @(posedge clock);
   endtask

   // drain all responses, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (placements.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // random sequences: init, then a run of places that mostly fit with an
   // occasional init in between, so the free list grows
   task automatic random_phase(int unsigned count);
      logic [CoordBits-1:0] w, h;
      int unsigned          sel;
      send_item(ACT_INIT, CoordBits'($urandom), CoordBits'($urandom));
      for (int n = 1; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 4) begin
            send_item(ACT_INIT, CoordBits'($urandom), CoordBits'($urandom));
         end else begin
            if (sel < 80) begin
               w = CoordBits'($urandom_range(1, (placements.atlas_w >> 4) + 1));
               h = CoordBits'($urandom_range(1, (placements.atlas_h >> 4) + 1));
            end else if (sel < 92) begin
               w = CoordBits'($urandom_range(1, 32767));
               h = CoordBits'($urandom_range(1, 32767));
            end else begin
               w = placements.atlas_w;
               h = CoordBits'($urandom_range(1, placements.atlas_h + 1));
            end
            send_item(ACT_PLACE, w, h);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: place into the reset list, full-atlas fit, no fit, zero
      // sizes, extremes, remainders
      send_item(ACT_PLACE, 15'd100, 15'd50);
      send_item(ACT_INIT, '0, '0);
      send_item(ACT_PLACE, 15'd2048, 15'd2048);
      send_item(ACT_PLACE, 15'd1, 15'd1);
      send_item(ACT_INIT, 15'h7fff, 15'h7fff);
      send_item(ACT_PLACE, 15'd0, 15'd5);
      send_item(ACT_PLACE, 15'd7, 15'd0);
      send_item(ACT_PLACE, 15'h7fff, 15'h7fff);
      send_item(ACT_PLACE, 15'd1024, 15'd2048);
      send_item(ACT_PLACE, 15'd1024, 15'd2048);
      send_item(ACT_INIT, '0, '0);
      send_item(ACT_PLACE, 15'd2047, 15'd1);
      send_item(ACT_PLACE, 15'd1, 15'd2047);
      send_item(ACT_PLACE, 15'd1, 15'd1);
      send_item(ACT_PLACE, 15'd2047, 15'd2047);
      send_item(ACT_PLACE, 15'd1, 15'd1);

      // advance through idling modes and atlas sizes
      for (int p = 0; p < 6; p++) begin
         send_idle_pct = (p < 2) ? 31 : (p < 4) ? 64 : 0;
         recv_idle_pct = (p < 2) ? 64 : (p < 4) ? 31 : 0;
         if (p > 0) begin
            wait_idle();
            case (p)
               1: begin
                  write_reg(CSR_ATLAS_WIDTH, 15'h7fff);
                  write_reg(CSR_ATLAS_HEIGHT, 15'h7fff);
               end
               2: begin
                  write_reg(CSR_ATLAS_WIDTH, 15'd1);
                  write_reg(CSR_ATLAS_HEIGHT, 15'd1);
               end
               3: begin
                  write_reg(CSR_ATLAS_WIDTH, 15'd0);
                  write_reg(CSR_ATLAS_HEIGHT, CoordBits'($urandom));
               end
               default: begin
                  write_reg(CSR_ATLAS_WIDTH, CoordBits'($urandom_range(64, 32767)));
                  write_reg(CSR_ATLAS_HEIGHT, CoordBits'($urandom_range(64, 32767)));
               end
            endcase
            // a zero atlas yields little; keep that phase short
            if (p == 3) begin
               send_item(ACT_INIT, '0, '0);
               send_item(ACT_PLACE, 15'd0, 15'd0);
               send_item(ACT_PLACE, 15'd0, 15'd3);
               wait_idle();
               write_reg(CSR_ATLAS_WIDTH, CoordBits'($urandom_range(512, 4096)));
            end
         end
         random_phase(305);
      end

      wait_idle();
      repeat (600) @(posedge clock);
      if (placements.errors == 0 && placements.pending.size() == 0)
         $display("guillotine_best_area_fit_packer regression: pass");
      else
         $display("guillotine_best_area_fit_packer regression: fail");
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("guillotine_best_area_fit_packer regression: fail");
      $finish;
   end
endmodule
